// ----- rtl/utf8d_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8d_pkg
// Types, codes and decode helpers for the lenient UTF-8 decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int CP_W    = 21;
    localparam int BYTE_W  = 8;
    localparam int TDATA_W = 24;   // code point padded to whole bytes

    // Sequence length opened by a byte; value equals the byte count.
    typedef enum logic [2:0] {
        LEN_STRAY = 3'd0,
        LEN_1     = 3'd1,
        LEN_2     = 3'd2,
        LEN_3     = 3'd3,
        LEN_4     = 3'd4
    } len_t;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            last;
    } res_t;

    function automatic len_t seq_len(input logic [BYTE_W-1:0] b);
        len_t l;
        if ((b & 8'h80) == 8'h00)      l = LEN_1;
        else if ((b & 8'hE0) == 8'hC0) l = LEN_2;
        else if ((b & 8'hF0) == 8'hE0) l = LEN_3;
        else if ((b & 8'hF8) == 8'hF0) l = LEN_4;
        else                           l = LEN_STRAY;
        return l;
    endfunction

    function automatic logic [CP_W-1:0] cp2(input logic [BYTE_W-1:0] b0,
                                            input logic [BYTE_W-1:0] b1);
        return {10'd0, b0[4:0], b1[5:0]};
    endfunction

    function automatic logic [CP_W-1:0] cp3(input logic [BYTE_W-1:0] b0,
                                            input logic [BYTE_W-1:0] b1,
                                            input logic [BYTE_W-1:0] b2);
        return {5'd0, b0[3:0], b1[5:0], b2[5:0]};
    endfunction

    function automatic logic [CP_W-1:0] cp4(input logic [BYTE_W-1:0] b0,
                                            input logic [BYTE_W-1:0] b1,
                                            input logic [BYTE_W-1:0] b2,
                                            input logic [BYTE_W-1:0] b3);
        return {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
    endfunction

endpackage

// ----- rtl/utf8_lenient_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8_lenient_decoder
// Lenient streaming UTF-8 decoder: one text byte in, zero to two code points out.
// ----------------------------------------------------------------------------
// Results are registered: a result is on the master side in the cycle after its byte is taken.
// Throughput: one byte per cycle while m_axis_tready is high; a byte that yields two
//   code points holds the slave side while the two-entry result queue drains.
// Reset (rst_n low, asynchronous): no sequence open, result queue empty.
//   Buffered sequence bytes are not cleared; they are read only once written.
// ----------------------------------------------------------------------------
module utf8_lenient_decoder
    import utf8d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // input byte stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [BYTE_W-1:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic               s_axis_tlast,   // end_of_text
    // code point stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic               m_axis_tlast    // run_last
);

    // ------------------------------------------------------------------------
    // Open sequence: lead byte plus up to two continuation bytes.
    // pend_cnt_reg == 0 means no sequence is open.
    // ------------------------------------------------------------------------
    logic [1:0]        pend_cnt_reg, pend_cnt_next;
    logic [BYTE_W-1:0] pend0_reg, pend0_next;
    logic [BYTE_W-1:0] pend1_reg, pend1_next;
    logic [BYTE_W-1:0] pend2_reg, pend2_next;

    // Result queue, two entries; q0 is the head.
    logic [1:0] q_cnt_reg, q_cnt_next;
    res_t       q0_reg, q0_next;
    res_t       q1_reg, q1_next;

    logic       accept;
    logic       pop;

    // Decode of the current byte
    logic [BYTE_W-1:0] byte_in;
    logic              eot;
    len_t              in_len;
    len_t              lead_len;
    len_t              p1_len;
    logic [2:0]        n_have;      // bytes of the sequence including this one
    logic [1:0]        n_res;
    res_t              r0, r1;

    assign byte_in  = s_axis_tdata;
    assign eot      = s_axis_tlast;
    assign in_len   = seq_len(byte_in);
    assign lead_len = seq_len(pend0_reg);
    assign p1_len   = seq_len(pend1_reg);
    assign n_have   = {1'b0, pend_cnt_reg} + 3'd1;

    // Accept only when the queue is empty after this cycle's pop, so both
    // possible results of the byte always fit.
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (q_cnt_reg == 2'd0) || ((q_cnt_reg == 2'd1) && m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        n_res         = 2'd0;
        r0.cp         = {13'd0, byte_in};
        r1.cp         = {13'd0, byte_in};
        pend_cnt_next = pend_cnt_reg;
        pend0_next    = pend0_reg;
        pend1_next    = pend1_reg;
        pend2_next    = pend2_reg;

        if (pend_cnt_reg == 2'd0)
        begin
            if (in_len == LEN_1)
            begin
                n_res = 2'd1;
            end
            else if (in_len != LEN_STRAY && !eot)
            begin
                // lead byte opens a sequence
                pend0_next    = byte_in;
                pend_cnt_next = 2'd1;
            end
        end
        else if (n_have >= lead_len)
        begin
            // sequence complete
            n_res         = 2'd1;
            pend_cnt_next = 2'd0;
            case (lead_len)
                LEN_2:   r0.cp = cp2(pend0_reg, byte_in);
                LEN_3:   r0.cp = cp3(pend0_reg, pend1_reg, byte_in);
                default: r0.cp = cp4(pend0_reg, pend1_reg, pend2_reg, byte_in);
            endcase
        end
        else if (eot)
        begin
            // string ends inside a sequence: drop the lead, redo the tail
            pend_cnt_next = 2'd0;
            if (pend_cnt_reg == 2'd1)
            begin
                if (in_len == LEN_1)
                    n_res = 2'd1;
            end
            else if (p1_len == LEN_1)
            begin
                r0.cp = {13'd0, pend1_reg};
                n_res = (in_len == LEN_1) ? 2'd2 : 2'd1;
            end
            else if (p1_len == LEN_2)
            begin
                r0.cp = cp2(pend1_reg, byte_in);
                n_res = 2'd1;
            end
            else if (in_len == LEN_1)
            begin
                // tail lead incomplete or stray: only the final byte may pass
                n_res = 2'd1;
            end
        end
        else
        begin
            // buffer another continuation byte
            if (pend_cnt_reg == 2'd1)
                pend1_next = byte_in;
            else
                pend2_next = byte_in;
            pend_cnt_next = pend_cnt_reg + 2'd1;
        end

        r0.last = (n_res == 2'd1);
        r1.last = 1'b1;
    end

    // Queue update
    always_comb
    begin
        q_cnt_next = q_cnt_reg;
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        if (accept)
        begin
            q_cnt_next = n_res;
            q0_next    = r0;
            q1_next    = r1;
        end
        else if (pop)
        begin
            q_cnt_next = q_cnt_reg - 2'd1;
            q0_next    = q1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg <= 2'd0;
            q_cnt_reg    <= 2'd0;
        end
        else
        begin
            if (accept)
                pend_cnt_reg <= pend_cnt_next;
            q_cnt_reg <= q_cnt_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend0_reg <= pend0_next;
            pend1_reg <= pend1_next;
            pend2_reg <= pend2_next;
        end
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign m_axis_tvalid = (q_cnt_reg != 2'd0);
    assign m_axis_tdata  = {{(TDATA_W-CP_W){1'b0}}, q0_reg.cp};
    assign m_axis_tlast  = q0_reg.last;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // queue never overfills
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg != 2'd3)
        else $error("result queue count out of range");

    // a full queue holds a byte's second result, which closes its run
    a_q_second_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg == 2'd2 |-> q1_reg.last)
        else $error("second queued result not marked last");

    // three buffered bytes only for a 4-byte lead
    a_cnt3_len4: assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt_reg == 2'd3 |-> lead_len == LEN_4)
        else $error("three buffered bytes without a 4-byte lead");

    // end of text always closes the open sequence
    a_eot_closes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && eot |=> pend_cnt_reg == 2'd0)
        else $error("sequence still open after end of text");

endmodule
